[hw/rtl/mif_pkg.sv]
`default_nettype none
package mif_pkg;
   typedef enum logic [3:0] {
      KIND_STORE_LE = 4'd0, KIND_STORE_BE = 4'd1, KIND_STORE_OTHER = 4'd2,
      KIND_CLAIM = 4'd3, KIND_WR_PEND = 4'd4, KIND_WR_EN = 4'd5,
      KIND_RD_PEND = 4'd6, KIND_RD_EN = 4'd7, KIND_LOAD = 4'd8
   } kind_type;

   localparam int ID_W = 11;
   localparam logic [3:0] PAGE_ACCESS_BYTES = 4'd4;

   // register byte addresses
   localparam logic [2:0] CSR_ADDR_DELIVERY = 3'd0;
   localparam logic [2:0] CSR_ADDR_THRESHOLD = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE, OP_SET, OP_CLR, OP_WR_PEND, OP_WR_EN, OP_RD_PEND, OP_RD_EN
   } op_type;

   // one classified item
   typedef struct packed {
      op_type      op;
      logic        ok;
      logic [4:0]  widx;
      logic [5:0]  bidx;
      logic [63:0] data;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);
endpackage
`default_nettype wire

[hw/rtl/mif_front.sv]
`default_nettype none
module mif_front
   import mif_pkg::*;
#(
   parameter int NUM_WORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [3:0]  kind,
   input  wire logic [3:0]  access_size,
   input  wire logic [31:0] store_data,
   input  wire logic [10:0] claim_id,
   input  wire logic [4:0]  word_index,
   input  wire logic [63:0] word_data,
   output logic             q_valid,
   input  wire logic        q_ready,
   output cmd_type          q_cmd
);
   cmd_type    cmd;
   logic [31:0] id;
   logic        id_ok;
   logic        page;

   always_comb begin
      cmd = '0;
      cmd.op = OP_NONE;
      cmd.ok = 1'b1;
      cmd.widx = word_index;
      cmd.data = word_data;
      page = (kind == KIND_STORE_LE) || (kind == KIND_STORE_BE) ||
             (kind == KIND_STORE_OTHER) || (kind == KIND_LOAD);
      id = (kind == KIND_STORE_BE) ?
           {store_data[7:0], store_data[15:8], store_data[23:16], store_data[31:24]} :
           store_data;
      if (kind == KIND_CLAIM) id = {21'd0, claim_id};
      id_ok = (id != 32'd0) && (id < 32'(64 * NUM_WORDS));
      if (page && access_size != PAGE_ACCESS_BYTES) begin
         cmd.ok = 1'b0;
      end else begin
         case (kind)
            KIND_STORE_LE, KIND_STORE_BE, KIND_CLAIM: begin
               if (id_ok) begin
                  cmd.op = (kind == KIND_CLAIM) ? OP_CLR : OP_SET;
                  cmd.widx = id[10:6];
                  cmd.bidx = id[5:0];
               end
            end
            KIND_WR_PEND: cmd.op = OP_WR_PEND;
            KIND_WR_EN:   cmd.op = OP_WR_EN;
            KIND_RD_PEND: cmd.op = OP_RD_PEND;
            KIND_RD_EN:   cmd.op = OP_RD_EN;
            default:      cmd.op = OP_NONE;
         endcase
      end
   end

   // two-entry queue
   cmd_type    q_mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ptr_ff, wr_ptr_ff;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_cmd = q_mem_ff[rd_ptr_ff];
   assign cnt_in = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
      if (push) q_mem_ff[wr_ptr_ff] <= cmd;
   end
endmodule
`default_nettype wire

[hw/rtl/mif_back.sv]
`default_nettype none
module mif_back
   import mif_pkg::*;
#(
   parameter int NUM_WORDS = 32,
   parameter int IMPLEMENTED_WORDS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   output logic             q_ready,
   input  wire cmd_type     q_cmd,
   input  wire logic        delivery_enable,
   input  wire logic [10:0] threshold,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic             out_ok,
   output logic [63:0]      out_rdata,
   output logic [10:0]      out_top,
   output logic             out_irq
);
   localparam int LIVE = (NUM_WORDS < IMPLEMENTED_WORDS) ? NUM_WORDS : IMPLEMENTED_WORDS;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type   state_ff;
   logic [63:0] pend_ff [32];
   logic [63:0] en_ff [32];
   logic [4:0]  scan_ff;
   logic        found_ff;
   logic [10:0] id_ff;
   logic        ok_ff, irq_ff;
   logic [63:0] rdata_ff;
   logic [10:0] top_ff;

   logic        live;
   logic [63:0] wmask, rd_word, hits;
   logic [5:0]  low;
   logic [10:0] top_c;

   assign live = (32'(q_cmd.widx) < LIVE);
   assign wmask = (q_cmd.widx == 5'd0) ? ~64'd1 : ~64'd0;

   always_comb begin
      rd_word = (q_cmd.op == OP_RD_PEND) ? pend_ff[q_cmd.widx] : en_ff[q_cmd.widx];
      if (!live || !((q_cmd.op == OP_RD_PEND) || (q_cmd.op == OP_RD_EN))) rd_word = '0;
      hits = pend_ff[scan_ff] & en_ff[scan_ff];
      if (scan_ff == 5'd0) hits[0] = 1'b0;
      if (32'(scan_ff) >= LIVE) hits = '0;
      low = 6'd0;
      for (int i = 63; i >= 0; i--) if (hits[i]) low = 6'(i);
      top_c = id_ff;
      if (!found_ff) top_c = 11'd0;
      else if (threshold != 11'd0 && id_ff >= threshold) top_c = 11'd0;
   end

   assign q_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_ok = ok_ff;
   assign out_rdata = rdata_ff;
   assign out_top = top_ff;
   assign out_irq = irq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 32; i++) begin
            pend_ff[i] <= '0;
            en_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: if (q_valid) begin
               ok_ff <= q_cmd.ok;
               rdata_ff <= rd_word & wmask;
               if (live) begin
                  case (q_cmd.op)
                     OP_SET: pend_ff[q_cmd.widx][q_cmd.bidx] <= 1'b1;
                     OP_CLR: pend_ff[q_cmd.widx][q_cmd.bidx] <= 1'b0;
                     OP_WR_PEND: pend_ff[q_cmd.widx] <= q_cmd.data & wmask;
                     OP_WR_EN: en_ff[q_cmd.widx] <= q_cmd.data & wmask;
                     default: ;
                  endcase
               end
               scan_ff <= '0;
               found_ff <= 1'b0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!found_ff && hits != 64'd0) begin
                  found_ff <= 1'b1;
                  id_ff <= {scan_ff, low};
               end
               if (scan_ff == 5'd31) state_ff <= S_DONE;
               else scan_ff <= scan_ff + 5'd1;
            end
            S_DONE: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_SCAN && scan_ff == 5'd31) begin
            top_ff <= (!found_ff && hits != 64'd0) ?
                      ((threshold != 11'd0 && {scan_ff, low} >= threshold) ? 11'd0 : {scan_ff, low})
                      : top_c;
            irq_ff <= delivery_enable &&
                      (((!found_ff && hits != 64'd0) ?
                      ((threshold != 11'd0 && {scan_ff, low} >= threshold) ? 11'd0 : {scan_ff, low})
                      : top_c) != 11'd0);
         end
      end
   end
endmodule
`default_nettype wire

[hw/rtl/msi_interrupt_file_unit.sv]
`default_nettype none
// Message-signalled interrupt file. One result item per request item. The
// front classifies items into a two-entry queue; the back applies an item
// and then scans the 32 pending/enable words, one word per cycle, for the
// top identity. The back takes a new item only after it has handed off the
// result of the last one (apply, scan of the 32 words, result handoff); the
// scan sets the rate. A stalled result holds the back, the queue fills and
// req_tready drops.
// Registers: delivery enable at byte 0, priority threshold at byte 4; write
// them only while no item is in flight.
module msi_interrupt_file_unit
   import mif_pkg::*;
#(
   parameter int NUM_WORDS = 32,
   parameter int IMPLEMENTED_WORDS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // kind[3:0], access_size[7:4], store_data[39:8], claim_id[50:40],
   // word_index[55:51], word_data[119:56]
   input  wire logic [119:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // access_ok[0], read_data[64:1], top_id[75:65], ext_irq[76]
   output logic [79:0]       rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic        de_ff;
   logic [10:0] thr_ff;
   logic        qv, qr;
   cmd_type     qc;
   logic        ok, irq;
   logic [63:0] rd;
   logic [10:0] top;

   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr)
         CSR_ADDR_DELIVERY: csr_prdata = {31'd0, de_ff};
         CSR_ADDR_THRESHOLD: csr_prdata = {21'd0, thr_ff};
         default: csr_prdata = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         de_ff <= 1'b0;
         thr_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == CSR_ADDR_DELIVERY) de_ff <= csr_pwdata[0];
         if (csr_paddr == CSR_ADDR_THRESHOLD) thr_ff <= csr_pwdata[10:0];
      end
   end

   mif_front #(.NUM_WORDS(NUM_WORDS)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .kind(req_tdata[3:0]), .access_size(req_tdata[7:4]),
      .store_data(req_tdata[39:8]), .claim_id(req_tdata[50:40]),
      .word_index(req_tdata[55:51]), .word_data(req_tdata[119:56]),
      .q_valid(qv), .q_ready(qr), .q_cmd(qc));

   mif_back #(.NUM_WORDS(NUM_WORDS), .IMPLEMENTED_WORDS(IMPLEMENTED_WORDS)) u_back (
      .clock, .reset, .q_valid(qv), .q_ready(qr), .q_cmd(qc),
      .delivery_enable(de_ff), .threshold(thr_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_ok(ok), .out_rdata(rd), .out_top(top), .out_irq(irq));

   assign rsp_tdata = {3'd0, irq, top, rd, ok};
endmodule
`default_nettype wire

[hw/rtl/msi_interrupt_file_checker.sv]
`default_nettype none
module msi_interrupt_file_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic        csr_pready
);
   a_irq: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[76] |-> rsp_tdata[75:65] != 11'd0)
      else $error("irq with zero top");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_rdy: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule
bind msi_interrupt_file_unit msi_interrupt_file_checker u_chk (.*);
`default_nettype wire

[verif/msi_interrupt_file_unit_checker.sv]
`timescale 1ns / 100ps
module msi_interrupt_file_unit_checker
   import mif_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [119:0] req_tdata,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [79:0]  rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output int                fail_count,
   output int                rsp_owed
);
   typedef struct packed {
      logic        irq;
      logic [10:0] top;
      logic [63:0] rdata;
      logic        ok;
   } rsp_fields_type;

   logic [63:0]    pend_word [32];
   logic [63:0]    en_word [32];
   logic           deliver;
   logic [10:0]    threshold;
   rsp_fields_type owed_q [$];

   function automatic logic [10:0] top_identity();
      logic [63:0] hits;
      for (int w = 0; w < 32; w++) begin
         hits = pend_word[w] & en_word[w];
         if (w == 0) hits[0] = 1'b0;
         if (hits != 0) begin
            for (int b = 0; b < 64; b++) begin
               if (hits[b]) begin
                  if (threshold != 0 && (w * 64 + b) >= threshold) return 11'd0;
                  return 11'(w * 64 + b);
               end
            end
         end
      end
      return 11'd0;
   endfunction

   task automatic mark_id(input logic [31:0] id, input logic value);
      if (id == 0 || id >= 2048) return;
      pend_word[id[10:6]][id[5:0]] = value;
      pend_word[0][0] = 1'b0;
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic apply_item(input logic [119:0] d);
      rsp_fields_type r;
      logic [3:0]     kind;
      logic [31:0]    sd;
      logic [4:0]     wi;
      logic [63:0]    wd;
      kind = d[3:0];
      sd = d[39:8];
      wi = d[55:51];
      wd = d[119:56];
      r.ok = 1'b1;
      r.rdata = '0;
      case (kind)
         KIND_STORE_LE, KIND_STORE_BE, KIND_STORE_OTHER, KIND_LOAD: begin
            if (d[7:4] != PAGE_ACCESS_BYTES) r.ok = 1'b0;
            else if (kind == KIND_STORE_LE) mark_id(sd, 1'b1);
            else if (kind == KIND_STORE_BE) mark_id({sd[7:0], sd[15:8], sd[23:16], sd[31:24]}, 1'b1);
         end
         KIND_CLAIM: mark_id({21'd0, d[50:40]}, 1'b0);
         KIND_WR_PEND: begin
            pend_word[wi] = wd;
            if (wi == 0) pend_word[0][0] = 1'b0;
         end
         KIND_WR_EN: begin
            en_word[wi] = wd;
            if (wi == 0) en_word[0][0] = 1'b0;
         end
         KIND_RD_PEND: r.rdata = pend_word[wi];
         KIND_RD_EN: r.rdata = en_word[wi];
         default: ;
      endcase
      r.top = top_identity();
      r.irq = deliver && r.top != 0;
      owed_q.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_fields_type got, want;
      if (reset) begin
         for (int w = 0; w < 32; w++) begin
            pend_word[w] = '0;
            en_word[w] = '0;
         end
         deliver = 1'b0;
         threshold = '0;
         owed_q.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr == CSR_ADDR_DELIVERY) deliver = csr_pwdata[0];
            else if (csr_paddr == CSR_ADDR_THRESHOLD) threshold = csr_pwdata[10:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[76:0];
            if (owed_q.size() == 0) report("unexpected item", 64'(got), 0);
            else begin
               want = owed_q.pop_front();
               if (got.ok !== want.ok) report("access_ok", 64'(got.ok), 64'(want.ok));
               if (got.rdata !== want.rdata) report("read_data", got.rdata, want.rdata);
               if (got.top !== want.top) report("top_id", 64'(got.top), 64'(want.top));
               if (got.irq !== want.irq) report("ext_irq", 64'(got.irq), 64'(want.irq));
            end
         end
         if (req_tvalid && req_tready) apply_item(req_tdata);
      end
      rsp_owed = owed_q.size();
   end
endmodule

[verif/msi_interrupt_file_unit_tb.sv]
`timescale 1ns / 100ps
module msi_interrupt_file_unit_tb;
   import mif_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           rsp_owed;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_off = 0;
   int           cycle_count = 0;

   localparam int CYCLE_LIMIT = 1500000;

   msi_interrupt_file_unit dut (.*);

   msi_interrupt_file_unit_checker chk (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("msi_interrupt_file_unit: mismatch");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      csr_pwrite <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (rsp_owed != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // tvalid stays high into the next item unless the sender idles
   task automatic send(input logic [3:0] kind, input logic [3:0] size, input logic [31:0] sd,
                       input logic [10:0] cid, input logic [4:0] wi, input logic [63:0] wd);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {wd, wi, cid, sd, size, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] sparse64();
      logic [63:0] v = '0;
      repeat ($urandom_range(3)) v[$urandom_range(63)] = 1'b1;
      return v;
   endfunction

   task automatic random_item();
      int          sel;
      logic [10:0] id;
      logic [31:0] sd;
      logic [3:0]  size;
      sel = $urandom_range(99);
      id = 11'($urandom());
      size = ($urandom_range(9) == 0) ? 4'($urandom()) : PAGE_ACCESS_BYTES;
      sd = ($urandom_range(7) == 0) ? $urandom() : {21'd0, id};
      if (sel < 25) send(KIND_STORE_LE, size, sd, 11'($urandom()), 5'($urandom()), rand64());
      else if (sel < 35)
         send(KIND_STORE_BE, size, {sd[7:0], sd[15:8], sd[23:16], sd[31:24]},
              11'($urandom()), 5'($urandom()), rand64());
      else if (sel < 55) send(KIND_CLAIM, 4'($urandom()), $urandom(), id, 5'($urandom()), rand64());
      else if (sel < 62) send(KIND_WR_PEND, 4'($urandom()), $urandom(), id, 5'($urandom()),
                              ($urandom_range(1) ? rand64() : sparse64()));
      else if (sel < 74) send(KIND_WR_EN, 4'($urandom()), $urandom(), id, 5'($urandom()),
                              ($urandom_range(1) ? rand64() : ~sparse64()));
      else if (sel < 84) send(KIND_RD_PEND, 4'($urandom()), $urandom(), id, 5'($urandom()), rand64());
      else if (sel < 92) send(KIND_RD_EN, 4'($urandom()), $urandom(), id, 5'($urandom()), rand64());
      else if (sel < 95) send(KIND_STORE_OTHER, size, $urandom(), id, 5'($urandom()), rand64());
      else if (sel < 98) send(KIND_LOAD, size, $urandom(), id, 5'($urandom()), rand64());
      else send(4'($urandom_range(15, 9)), 4'($urandom()), $urandom(), id, 5'($urandom()), rand64());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_write(CSR_ADDR_DELIVERY, 32'd1);
      csr_write(CSR_ADDR_THRESHOLD, 32'd0);

      // directed: extremes, both endiannesses, bad sizes, word 0 bit 0
      send(KIND_WR_EN, 4'd4, 0, 0, 5'd0, '1);
      send(KIND_WR_EN, 4'd4, 0, 0, 5'd31, '1);
      send(KIND_STORE_LE, 4'd4, 32'd0, 0, 0, 0);
      send(KIND_STORE_LE, 4'd4, 32'd1, 0, 0, 0);
      send(KIND_STORE_LE, 4'd4, 32'd2047, 0, 0, 0);
      send(KIND_STORE_LE, 4'd4, 32'd2048, 0, 0, 0);
      send(KIND_STORE_LE, 4'd4, 32'hFFFF_FFFF, 0, 0, 0);
      send(KIND_STORE_BE, 4'd4, 32'h0500_0000, 0, 0, 0);
      send(KIND_STORE_LE, 4'd3, 32'd9, 0, 0, 0);
      send(KIND_STORE_BE, 4'd15, 32'd9, 0, 0, 0);
      send(KIND_STORE_OTHER, 4'd4, 32'd9, 0, 0, 0);
      send(KIND_STORE_OTHER, 4'd0, 32'd9, 0, 0, 0);
      send(KIND_LOAD, 4'd4, 0, 0, 0, 0);
      send(KIND_LOAD, 4'd8, 0, 0, 0, 0);
      send(KIND_RD_PEND, 0, 0, 0, 5'd0, 0);
      send(KIND_RD_PEND, 0, 0, 0, 5'd31, 0);
      send(KIND_CLAIM, 0, 0, 11'd0, 0, 0);
      send(KIND_CLAIM, 0, 0, 11'd1, 0, 0);
      send(KIND_CLAIM, 0, 0, 11'd5, 0, 0);
      send(KIND_WR_PEND, 0, 0, 0, 5'd0, '1);
      send(KIND_RD_PEND, 0, 0, 0, 5'd0, 0);
      send(KIND_RD_EN, 0, 0, 0, 5'd0, 0);
      send(KIND_WR_EN, 0, 0, 0, 5'd0, 0);
      send(4'd15, 4'd15, '1, '1, '1, '1);
      send(4'd9, 0, 0, 0, 0, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         csr_write(CSR_ADDR_DELIVERY, 32'(ph[0]));
         case (ph)
            0: csr_write(CSR_ADDR_THRESHOLD, 32'd0);
            1: csr_write(CSR_ADDR_THRESHOLD, 32'd2047);
            2: csr_write(CSR_ADDR_THRESHOLD, 32'd1);
            3: csr_write(CSR_ADDR_THRESHOLD, 32'd2);
            default: csr_write(CSR_ADDR_THRESHOLD, 32'($urandom_range(2047)));
         endcase
         if (ph == 4) begin
            send_idle_pct = 0;
            @(negedge clock);
            hold_off <= 400;
         end
         for (int n = 0; n < 200; n++) begin
            random_item();
            if (n == 100) begin
               req_tvalid <= 1'b0;
               while (rsp_owed != 0) @(negedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("msi_interrupt_file_unit: match");
      end else begin
         $display("msi_interrupt_file_unit: mismatch");
      end
      $finish;
   end
endmodule
